// ----- hw/rtl/sws_pkg.sv -----
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants for the searchable stack
// Item formats, opcode and status codes, and the command passed from the
// front end to the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  // Stack geometry
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;

  // Command queue geometry
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Opcodes as they arrive
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DISPLAY = 3'd3,
    OP_SEARCH  = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Input item
  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // Result item
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item;
    logic [POS_W-1:0]         position;
    logic                     last;
  } res_t;

  // Decoded command kinds
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK,
    CMD_DISPLAY,
    CMD_SEARCH
  } kind_t;

  // Command held in the queue
  typedef struct packed {
    kind_t                    kind;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sws_front.sv -----
// ----------------------------------------------------------------------------
// sws_front: command decode
// Accepts items, drops undefined opcodes and turns the rest into queue
// commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_front (
  input  wire              start,
  input  wire              q_full,
  input  sws_pkg::req_t    request,
  output logic             busy,
  output logic             enq,
  output sws_pkg::cmd_t    cmd
);

  logic valid_op;

  // Classify the opcode
  always_comb begin
    valid_op   = 1'b1;
    cmd.value  = request.value;
    cmd.kind   = sws_pkg::CMD_PUSH;
    case (request.opcode)
      sws_pkg::OP_PUSH:    cmd.kind = sws_pkg::CMD_PUSH;
      sws_pkg::OP_POP:     cmd.kind = sws_pkg::CMD_POP;
      sws_pkg::OP_PEEK:    cmd.kind = sws_pkg::CMD_PEEK;
      sws_pkg::OP_DISPLAY: cmd.kind = sws_pkg::CMD_DISPLAY;
      sws_pkg::OP_SEARCH:  cmd.kind = sws_pkg::CMD_SEARCH;
      default:             valid_op = 1'b0;  // undefined opcodes have no effect
    endcase
  end

  // Accept whenever the queue has room
  assign busy = q_full;
  assign enq  = start && !q_full && valid_op;

endmodule

`default_nettype wire

// ----- hw/rtl/sws_queue.sv -----
// ----------------------------------------------------------------------------
// sws_queue: command queue
// Small FIFO decoupling command decode from execution.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              enq,
  input  sws_pkg::cmd_t    enq_cmd,
  input  wire              deq,
  output sws_pkg::cmd_t    head,
  output logic             empty,
  output logic             full
);

  sws_pkg::cmd_t                slots [sws_pkg::QDEPTH];
  logic [sws_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sws_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sws_pkg::QCNT_W-1:0]   count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == sws_pkg::QCNT_W'(sws_pkg::QDEPTH));

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (enq) slots[wr_ptr] <= enq_cmd;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sws_back.sv -----
// ----------------------------------------------------------------------------
// sws_back: stack execution unit
// Owns the entry memory and fill count, runs one command at a time and
// drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              q_empty,
  input  sws_pkg::cmd_t    q_cmd,
  output logic             deq,
  output logic             strobe,
  output sws_pkg::res_t    result
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WALK, S_FLUSH} state_t;

  state_t                            state, state_next;
  logic [sws_pkg::CNT_W-1:0]         fill, fill_next;
  logic [sws_pkg::CNT_W-1:0]         pos, pos_next;
  sws_pkg::kind_t                    kind, kind_next;
  logic signed [sws_pkg::DATA_W-1:0] key, key_next;
  logic                              hold_valid, hold_valid_next;
  logic signed [sws_pkg::DATA_W-1:0] hold_item, hold_item_next;
  logic [sws_pkg::CNT_W-1:0]         hold_pos, hold_pos_next;
  logic                              emit;
  sws_pkg::res_t                     emit_res;

  logic signed [sws_pkg::DATA_W-1:0] mem [sws_pkg::DEPTH];
  logic signed [sws_pkg::DATA_W-1:0] rdata;
  logic [sws_pkg::ADDR_W-1:0]        raddr;
  logic                              we;
  logic                              at_end;

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[fill[sws_pkg::ADDR_W-1:0]] <= q_cmd.value;
    rdata <= mem[raddr];
  end

  assign at_end = (pos == fill);

  // Command sequencing
  always_comb begin
    state_next      = state;
    fill_next       = fill;
    pos_next        = pos;
    kind_next       = kind;
    key_next        = key;
    hold_valid_next = hold_valid;
    hold_item_next  = hold_item;
    hold_pos_next   = hold_pos;
    emit            = 1'b0;
    emit_res        = '0;
    deq             = 1'b0;
    we              = 1'b0;
    raddr           = '0;
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          deq       = 1'b1;
          kind_next = q_cmd.kind;
          key_next  = q_cmd.value;
          emit      = 1'b1;
          if (q_cmd.kind == sws_pkg::CMD_PUSH) begin
            if (fill == sws_pkg::CNT_W'(sws_pkg::DEPTH)) begin
              emit_res = '{status: sws_pkg::ST_OVERFLOW, item: '0, position: '0, last: 1'b1};
            end else begin
              we        = 1'b1;
              fill_next = fill + 1'b1;
              emit_res  = '{status: sws_pkg::ST_OK, item: q_cmd.value,
                            position: sws_pkg::POS_W'(1), last: 1'b1};
            end
          end else if (fill == '0) begin
            emit_res = '{status: sws_pkg::ST_EMPTY, item: '0, position: '0, last: 1'b1};
          end else begin
            // Start a read of the top entry
            emit            = 1'b0;
            raddr           = sws_pkg::ADDR_W'(fill - 1'b1);
            pos_next        = sws_pkg::CNT_W'(1);
            hold_valid_next = 1'b0;
            if (q_cmd.kind == sws_pkg::CMD_POP) fill_next = fill - 1'b1;
            if (q_cmd.kind == sws_pkg::CMD_POP || q_cmd.kind == sws_pkg::CMD_PEEK)
              state_next = S_READ;
            else
              state_next = S_WALK;
          end
        end
      end
      S_READ: begin
        emit       = 1'b1;
        emit_res   = '{status: sws_pkg::ST_OK, item: rdata,
                       position: sws_pkg::POS_W'(1), last: 1'b1};
        state_next = S_IDLE;
      end
      S_WALK: begin
        // rdata holds the entry at position pos; prefetch the next one down
        if (!at_end) begin
          raddr    = sws_pkg::ADDR_W'(fill - pos - 1'b1);
          pos_next = pos + 1'b1;
        end
        if (kind == sws_pkg::CMD_DISPLAY) begin
          emit     = 1'b1;
          emit_res = '{status: sws_pkg::ST_OK, item: rdata,
                       position: sws_pkg::POS_W'(pos), last: at_end};
          if (at_end) state_next = S_IDLE;
        end else begin
          // Hold each match back one step so the final one can carry last
          if (rdata == key) begin
            emit            = hold_valid;
            emit_res        = '{status: sws_pkg::ST_OK, item: hold_item,
                                position: sws_pkg::POS_W'(hold_pos), last: 1'b0};
            hold_valid_next = 1'b1;
            hold_item_next  = rdata;
            hold_pos_next   = pos;
          end
          if (at_end) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        emit = 1'b1;
        if (hold_valid)
          emit_res = '{status: sws_pkg::ST_OK, item: hold_item,
                       position: sws_pkg::POS_W'(hold_pos), last: 1'b1};
        else
          emit_res = '{status: sws_pkg::ST_NOTFOUND, item: '0, position: '0, last: 1'b1};
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      hold_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      hold_valid <= hold_valid_next;
      strobe     <= emit;
    end
    pos       <= pos_next;
    kind      <= kind_next;
    key       <= key_next;
    hold_item <= hold_item_next;
    hold_pos  <= hold_pos_next;
    result    <= emit_res;
  end

  // Fill count never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= sws_pkg::CNT_W'(sws_pkg::DEPTH))
    else $error("fill count above depth");

  // The walk position stays inside the stack
  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> (pos != '0 && pos <= fill))
    else $error("walk position out of range");

  // Any non-ok result closes its item
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.status != sws_pkg::ST_OK) |-> result.last)
    else $error("error result without last");

  // A pop or peek read always produces its result on the next cycle
  a_read_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> strobe)
    else $error("read cycle without result");

endmodule

`default_nettype wire

// ----- hw/rtl/stack_with_search.sv -----
// ----------------------------------------------------------------------------
// stack_with_search: LIFO stack of signed 32-bit values with linear search
// Push, pop, peek, top-down listing and key search over a 64-entry stack.
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+--------------------------------
//   command  | request (opcode, value) | taken when start && !busy
//   result   | result (status, item,   | valid for one cycle on strobe
//            |   position, last)       |
//
// Push completes from idle; pop/peek read the top entry; display and search walk
// the entries held one entry a cycle through the single read port of the entry memory.
// A two-entry command queue keeps start open while a command executes;
// busy rises only when the queue is full.
// Reset (rst, synchronous) empties the stack and the queue.
// Results cannot be held off; every result appears once on strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_search (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  sws_pkg::req_t    request,
  output logic             strobe,
  output sws_pkg::res_t    result
);

  logic          enq;
  logic          deq;
  logic          q_empty;
  logic          q_full;
  sws_pkg::cmd_t enq_cmd;
  sws_pkg::cmd_t head;

  sws_front u_front (
    .start   (start),
    .q_full  (q_full),
    .request (request),
    .busy    (busy),
    .enq     (enq),
    .cmd     (enq_cmd)
  );

  sws_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .deq     (deq),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  sws_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (head),
    .deq     (deq),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

`default_nettype wire
